[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define UCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define UCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ucd_pkg.sv]
// Shared types and constants of the undirected cycle detector
package ucd_pkg;

  localparam int FIELD_W  = 10;
  localparam int ACTION_W = 2;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 8;

  localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  typedef struct packed {
    logic latch_in;
    logic load_begin;
    logic clr_init;
    logic clr_write;
    logic edge_drop;
    logic edge_rd_a;
    logic edge_wr_a;
    logic edge_rd_b;
    logic edge_wr_b;
    logic root_init;
    logic root_rd;
    logic root_start;
    logic root_next;
    logic slot_rd;
    logic vis_rd;
    logic decide;
    logic pop;
    logic pop_load;
    logic out_load;
  } ucd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic edge_ok;
    logic root_done;
    logic root_visited;
    logic slot_end;
    logic depth_one;
    logic cycle_found;
    logic out_full;
  } ucd_stat_t;

endpackage

[design/ucd_ctrl.sv]
// Controller state machine of the undirected cycle detector
module ucd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ucd_pkg::ACTION_W-1:0] in_action,
  output logic                         in_ready,
  input  ucd_pkg::ucd_stat_t           stat,
  output ucd_pkg::ucd_cmd_t            cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EA_RD  = 4'd2;
  localparam logic [3:0] S_EA_WR  = 4'd3;
  localparam logic [3:0] S_EB_RD  = 4'd4;
  localparam logic [3:0] S_EB_WR  = 4'd5;
  localparam logic [3:0] S_R_RD   = 4'd6;
  localparam logic [3:0] S_R_CHK  = 4'd7;
  localparam logic [3:0] S_W_SLOT = 4'd8;
  localparam logic [3:0] S_W_VIS  = 4'd9;
  localparam logic [3:0] S_W_DEC  = 4'd10;
  localparam logic [3:0] S_W_POP  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.latch_in = accept;
    unique case (state)
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ucd_pkg::ACT_BEGIN: begin
              cmd.load_begin = 1'b1;
              cmd.clr_init   = 1'b1;
              state_next     = S_CLR;
            end
            ucd_pkg::ACT_EDGE: state_next = S_EA_RD;
            ucd_pkg::ACT_FINISH: begin
              cmd.root_init = 1'b1;
              state_next    = S_R_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EA_RD: begin
        if (stat.edge_ok) begin
          cmd.edge_rd_a = 1'b1;
          state_next    = S_EA_WR;
        end else begin
          cmd.edge_drop = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EA_WR: begin
        cmd.edge_wr_a = 1'b1;
        state_next    = S_EB_RD;
      end
      S_EB_RD: begin
        cmd.edge_rd_b = 1'b1;
        state_next    = S_EB_WR;
      end
      S_EB_WR: begin
        cmd.edge_wr_b = 1'b1;
        state_next    = S_IDLE;
      end
      S_R_RD: begin
        if (stat.root_done) begin
          state_next = S_OUT;
        end else begin
          cmd.root_rd = 1'b1;
          state_next  = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (stat.root_visited) begin
          cmd.root_next = 1'b1;
          state_next    = S_R_RD;
        end else begin
          cmd.root_start = 1'b1;
          state_next     = S_W_SLOT;
        end
      end
      S_W_SLOT: begin
        if (stat.cycle_found) begin
          state_next = S_R_RD;
        end else if (stat.slot_end) begin
          cmd.pop = 1'b1;
          if (stat.depth_one) begin
            cmd.root_next = 1'b1;
            state_next    = S_R_RD;
          end else begin
            state_next = S_W_POP;
          end
        end else begin
          cmd.slot_rd = 1'b1;
          state_next  = S_W_VIS;
        end
      end
      S_W_VIS: begin
        cmd.vis_rd = 1'b1;
        state_next = S_W_DEC;
      end
      S_W_DEC: begin
        cmd.decide = 1'b1;
        state_next = S_W_SLOT;
      end
      S_W_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_W_SLOT;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

[design/ucd_dp.sv]
// Datapath of the undirected cycle detector: adjacency store, marks, walk stack
module ucd_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ucd_pkg::FIELD_W-1:0]  in_count,
  input  logic [ucd_pkg::FIELD_W-1:0]  in_a,
  input  logic [ucd_pkg::FIELD_W-1:0]  in_b,
  input  ucd_pkg::ucd_cmd_t            cmd,
  output ucd_pkg::ucd_stat_t           stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_cycle,
  output logic                         out_overflow
);

  localparam int FW    = ucd_pkg::FIELD_W;
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = SW + 1;
  localparam int PW    = VW + 1;
  localparam int DW    = $clog2(MAX_VERTICES + 1);
  localparam int RW    = FW + 1;
  localparam int FRW   = VW + CW + 1 + PW;
  localparam logic [CW-1:0] NO_SLOT   = CW'(SLOTS);
  localparam logic [PW-1:0] NO_VERTEX = PW'(MAX_VERTICES);

  logic [CW-1:0]  head_mem [MAX_VERTICES];
  logic           vis_mem  [MAX_VERTICES];
  logic [VW-1:0]  nv_mem   [SLOTS];
  logic [CW-1:0]  nx_mem   [SLOTS];
  logic [FRW-1:0] stk_mem  [MAX_VERTICES];

  logic [CW-1:0]  head_q;
  logic           vis_q;
  logic [VW-1:0]  nv_q;
  logic [CW-1:0]  nx_q;
  logic [FRW-1:0] stk_q;

  logic [FW-1:0]  a_reg;
  logic [FW-1:0]  b_reg;
  logic [VW-1:0]  clr_addr;
  logic [CW-1:0]  slots_used;
  logic [FW-1:0]  root_count;
  logic [RW-1:0]  root;
  logic           cycle_found;
  logic           overflowed;
  logic [DW-1:0]  depth;
  logic [VW-1:0]  top_v;
  logic [CW-1:0]  top_cur;
  logic           top_skip;
  logic [PW-1:0]  top_par;
  logic [VW-1:0]  w;

  logic [VW-1:0]  a_v;
  logic [VW-1:0]  b_v;
  logic [VW-1:0]  root_v;
  logic [SW-1:0]  slot_a;
  logic [VW-1:0]  head_raddr;
  logic [VW-1:0]  vis_raddr;
  logic           head_we;
  logic [VW-1:0]  head_waddr;
  logic [CW-1:0]  head_wdata;
  logic           vis_we;
  logic [VW-1:0]  vis_waddr;
  logic           vis_wdata;
  logic           slot_we;
  logic [VW-1:0]  slot_nv;
  logic           stat_skip;

  assign a_v    = VW'(a_reg);
  assign b_v    = VW'(b_reg);
  assign root_v = VW'(root);
  assign slot_a = SW'(slots_used);

  always_comb begin
    head_raddr = a_v;
    vis_raddr  = root_v;
    if (cmd.edge_rd_b) head_raddr = b_v;
    if (cmd.root_rd)   head_raddr = root_v;
    if (cmd.vis_rd) begin
      head_raddr = nv_q;
      vis_raddr  = nv_q;
    end
  end

  always_comb begin
    head_we    = cmd.clr_write || cmd.edge_wr_a || cmd.edge_wr_b;
    head_waddr = clr_addr;
    head_wdata = NO_SLOT;
    slot_we    = cmd.edge_wr_a || cmd.edge_wr_b;
    slot_nv    = b_v;
    if (cmd.edge_wr_a) begin
      head_waddr = a_v;
      head_wdata = slots_used;
    end
    if (cmd.edge_wr_b) begin
      head_waddr = b_v;
      head_wdata = slots_used;
      slot_nv    = a_v;
    end
    vis_we    = cmd.clr_write || cmd.root_start || (cmd.decide && !vis_q && !stat_skip);
    vis_waddr = clr_addr;
    vis_wdata = 1'b0;
    if (cmd.root_start) begin
      vis_waddr = root_v;
      vis_wdata = 1'b1;
    end
    if (cmd.decide) begin
      vis_waddr = w;
      vis_wdata = 1'b1;
    end
  end

  assign stat_skip = ({1'b0, w} == top_par) && !top_skip;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      nv_mem[slot_a] <= slot_nv;
      nx_mem[slot_a] <= head_q;
    end
    nv_q <= nv_mem[SW'(top_cur)];
    nx_q <= nx_mem[SW'(top_cur)];
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && !stat_skip && !vis_q) begin
      stk_mem[VW'(depth - DW'(1))] <= {top_v, top_cur, top_skip, top_par};
    end
    stk_q <= stk_mem[VW'(depth - DW'(2))];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_reg <= in_a;
      b_reg <= in_b;
    end
    if (cmd.vis_rd) begin
      w       <= nv_q;
      top_cur <= nx_q;
    end
    if (cmd.root_start) begin
      top_v    <= root_v;
      top_cur  <= head_q;
      top_skip <= 1'b0;
      top_par  <= NO_VERTEX;
    end
    if (cmd.decide) begin
      if (stat_skip) begin
        top_skip <= 1'b1;
      end else if (!vis_q) begin
        top_v    <= w;
        top_cur  <= head_q;
        top_skip <= 1'b0;
        top_par  <= {1'b0, top_v};
      end
    end
    if (cmd.pop_load) begin
      {top_v, top_cur, top_skip, top_par} <= stk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      slots_used   <= '0;
      root_count   <= '0;
      root         <= '0;
      cycle_found  <= 1'b0;
      overflowed   <= 1'b0;
      depth        <= '0;
      out_valid    <= 1'b0;
      out_cycle    <= 1'b0;
      out_overflow <= 1'b0;
    end else begin
      if (cmd.clr_init) clr_addr <= '0;
      else if (cmd.clr_write) clr_addr <= clr_addr + VW'(1);
      if (cmd.load_begin) begin
        slots_used  <= '0;
        cycle_found <= 1'b0;
        overflowed  <= 1'b0;
        root_count  <= (32'(in_count) >= MAX_VERTICES) ? FW'(MAX_VERTICES - 1) : in_count;
      end
      if (cmd.edge_drop) overflowed <= 1'b1;
      if (cmd.edge_wr_a || cmd.edge_wr_b) slots_used <= slots_used + CW'(1);
      if (cmd.root_init) root <= RW'(1);
      else if (cmd.root_next) root <= root + RW'(1);
      if (cmd.root_start) depth <= DW'(1);
      if (cmd.decide && !stat_skip) begin
        if (vis_q) cycle_found <= 1'b1;
        else depth <= depth + DW'(1);
      end
      if (cmd.pop) depth <= depth - DW'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_load) begin
        out_valid    <= 1'b1;
        out_cycle    <= cycle_found;
        out_overflow <= overflowed;
      end
    end
  end

  always_comb begin
    stat              = '0;
    stat.clr_last     = (clr_addr == VW'(MAX_VERTICES - 1));
    stat.edge_ok      = (32'(a_reg) < MAX_VERTICES) && (32'(b_reg) < MAX_VERTICES)
                        && (32'(slots_used) + 2 <= SLOTS);
    stat.root_done    = (root > {1'b0, root_count}) || cycle_found;
    stat.root_visited = vis_q;
    stat.slot_end     = (top_cur >= slots_used);
    stat.depth_one    = (depth == DW'(1));
    stat.cycle_found  = cycle_found;
    stat.out_full     = out_valid;
  end

endmodule

[design/undirected_cycle_detect.sv]
// Top level of the undirected cycle detector
//
// channel  dir  tdata fields (low bit first)
// s_axis   in   action[1:0] vertex_count[11:2] end_a[21:12] end_b[31:22]
// m_axis   out  has_cycle[0] edge_overflow[1], zero fill [7:2]
//
// Begin: the input is taken, then a clearing sweep runs over every entry of the
// vertex store; the same sweep runs after reset. s_axis_tready stays low meanwhile.
// Edge: S_EA_RD, S_EA_WR, S_EB_RD and S_EB_WR read then write the two list heads.
// Finish: S_R_RD and S_R_CHK check each root, S_W_SLOT, S_W_VIS and S_W_DEC scan
// each edge slot, and S_W_SLOT with S_W_POP pops the walk stack.
// A finish result waits in the output register until m_axis_tready.
module undirected_cycle_detect #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ucd_pkg::IN_W-1:0]   s_axis_tdata,  // action, vertex_count, end_a, end_b
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ucd_pkg::OUT_W-1:0]  m_axis_tdata   // has_cycle, edge_overflow
);

  ucd_pkg::ucd_cmd_t  cmd;
  ucd_pkg::ucd_stat_t stat;
  logic               out_cycle;
  logic               out_overflow;

  ucd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tdata[1:0]),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ucd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_count     (s_axis_tdata[11:2]),
    .in_a         (s_axis_tdata[21:12]),
    .in_b         (s_axis_tdata[31:22]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_cycle    (out_cycle),
    .out_overflow (out_overflow)
  );

  assign m_axis_tdata = {6'b0, out_overflow, out_cycle};

endmodule

[design/ucd_checker.sv]
// Port checker of the undirected cycle detector and its bind
`include "assert_macros.svh"

module ucd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  `UCD_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `UCD_ASSERT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
  `UCD_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result present after reset")
  `UCD_ASSERT_ALWAYS(a_rst_sweep, clk, $past(rst) && !rst |-> !s_axis_tready, "input taken during clearing sweep")

endmodule

bind undirected_cycle_detect ucd_checker u_ucd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_undirected_cycle_detect.sv]
// Self-checking bench for the undirected cycle detector: graph streams in, verdicts checked
module tb_undirected_cycle_detect;

  localparam logic [ucd_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int N_VERT  = 1024;
  localparam int N_SLOTS = 2 * 4096;

  class cycle_scoreboard;
    int unsigned nbr[N_SLOTS];
    int unsigned nxt[N_SLOTS];
    int unsigned head[N_VERT];
    bit          seen[N_VERT];
    int unsigned par[N_VERT];
    int unsigned stk_v[N_VERT];
    int unsigned stk_c[N_VERT];
    bit          stk_s[N_VERT];
    int unsigned depth, slots, roots;
    bit          found, ovf;
    bit [1:0]    verdicts[$];
    int          errors, results, cycles_seen, drops_seen;

    function new();
      clear_graph();
      roots = 0;
    endfunction

    function void clear_graph();
      for (int i = 0; i < N_VERT; i++) begin
        head[i] = N_SLOTS;
        seen[i] = 0;
        par[i]  = N_VERT;
      end
      depth = 0;
      slots = 0;
      found = 0;
      ovf   = 0;
    endfunction

    function void link(int unsigned from, int unsigned to);
      nbr[slots] = to;
      nxt[slots] = head[from];
      head[from] = slots;
      slots++;
    endfunction

    function void push(int unsigned v);
      if (depth >= N_VERT) return;
      seen[v] = 1;
      stk_v[depth] = v;
      stk_c[depth] = head[v];
      stk_s[depth] = 0;
      depth++;
    endfunction

    function void walk(int unsigned root);
      int unsigned v, w;
      depth = 0;
      push(root);
      while (depth > 0 && !found) begin
        v = stk_v[depth-1];
        if (stk_c[depth-1] >= slots) begin
          depth--;
          continue;
        end
        w = nbr[stk_c[depth-1]];
        stk_c[depth-1] = nxt[stk_c[depth-1]];
        if (w >= N_VERT) continue;
        if (w == par[v] && !stk_s[depth-1]) begin
          stk_s[depth-1] = 1;
          continue;
        end
        if (!seen[w]) begin
          par[w] = v;
          push(w);
        end else begin
          found = 1;
        end
      end
      depth = 0;
    endfunction

    function void note_input(logic [ucd_pkg::ACTION_W-1:0] act, logic [9:0] cnt,
                             logic [9:0] a, logic [9:0] b);
      unique case (act)
        ucd_pkg::ACT_BEGIN: begin
          clear_graph();
          roots = (cnt >= N_VERT) ? N_VERT - 1 : cnt;
        end
        ucd_pkg::ACT_EDGE: begin
          if (a >= N_VERT || b >= N_VERT || slots + 2 > N_SLOTS) begin
            ovf = 1;
          end else begin
            link(a, b);
            link(b, a);
          end
        end
        ucd_pkg::ACT_FINISH: begin
          for (int unsigned r = 1; r <= roots && !found; r++)
            if (r < N_VERT && !seen[r]) walk(r);
          verdicts.insert(verdicts.size(), {ovf, found});
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [ucd_pkg::OUT_W-1:0] d);
      bit [1:0] e;
      results++;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = verdicts.pop_front();
      cycles_seen += d[0];
      drops_seen  += d[1];
      if (d[0] !== e[0] || d[1] !== e[1]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: has_cycle exp %0d got %0b, edge_overflow exp %0d got %0b",
                   e[0], d[0], e[1], d[1]);
      end
    endfunction
  endclass

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      s_axis_tvalid = 0;
  logic                      s_axis_tready;
  logic [ucd_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 0;
  logic [ucd_pkg::OUT_W-1:0] m_axis_tdata;

  cycle_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_go = 0;
  int sent = 0;

  undirected_cycle_detect dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(logic [ucd_pkg::ACTION_W-1:0] act, logic [9:0] cnt,
                           logic [9:0] a, logic [9:0] b);
    while (idle_on && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {b, a, cnt, act};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, cnt, a, b);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.verdicts.size() > 0) @(posedge clk);
  endtask

  task automatic random_graph();
    int unsigned vc, ne, mode;
    vc   = $urandom_range(1, 16);
    mode = $urandom_range(3);
    if ($urandom_range(14) == 0) begin
      vc = $urandom_range(1023);
      send_item(ucd_pkg::ACT_BEGIN, 10'(vc), 10'($urandom), 10'($urandom));
      repeat ($urandom_range(40))
        send_item(ucd_pkg::ACT_EDGE, 10'($urandom), 10'($urandom), 10'($urandom));
    end else begin
      send_item(ucd_pkg::ACT_BEGIN, 10'(vc), 10'($urandom), 10'($urandom));
      if (mode != 0) begin
        for (int unsigned v = 2; v <= vc + 1; v++)
          if ($urandom_range(5) != 0)
            send_item(ucd_pkg::ACT_EDGE, 10'($urandom), 10'(v), 10'($urandom_range(v - 1)));
        if (mode == 1)
          send_item(ucd_pkg::ACT_EDGE, 10'($urandom), 10'($urandom_range(vc + 1)),
                    10'($urandom_range(vc + 1)));
      end else begin
        ne = $urandom_range(12);
        repeat (ne)
          send_item(ucd_pkg::ACT_EDGE, 10'($urandom), 10'($urandom_range(vc + 1)),
                    10'($urandom_range(vc + 1)));
      end
    end
    if ($urandom_range(9) == 0)
      send_item(ACT_SPARE, 10'($urandom), 10'($urandom), 10'($urandom));
    send_item(ucd_pkg::ACT_FINISH, 10'($urandom), 10'($urandom), 10'($urandom));
    if ($urandom_range(7) == 0)
      send_item(ucd_pkg::ACT_FINISH, 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_go) begin
        hold_go = 0;
        m_axis_tready <= 0;
        repeat (6000) begin
          @(posedge clk);
          if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
      end
      m_axis_tready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed graphs
    send_item(ucd_pkg::ACT_FINISH, 10'h3ff, 10'h3ff, 10'h3ff);
    send_item(ucd_pkg::ACT_BEGIN, '0, '0, '0);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    send_item(ucd_pkg::ACT_BEGIN, 10'h3ff, '0, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'h3ff, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, '0, 10'd5);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    send_item(ucd_pkg::ACT_BEGIN, 10'd3, '0, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'd2, 10'd2);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    send_item(ucd_pkg::ACT_BEGIN, 10'd4, '0, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'd1, 10'd2);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'd2, 10'd1);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    send_item(ucd_pkg::ACT_BEGIN, 10'd2, '0, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'd1, '0);
    send_item(ucd_pkg::ACT_EDGE, '0, '0, 10'd2);
    send_item(ucd_pkg::ACT_EDGE, '0, 10'd2, 10'd1);
    send_item(ACT_SPARE, 10'h3ff, 10'h3ff, 10'h3ff);
    send_item(ucd_pkg::ACT_FINISH, '0, '0, '0);
    drain();

    while (sent < 1750) begin
      if (sent > 400 && sent < 420) hold_go = 1;
      idle_on = !(sent > 800 && sent < 1100);
      if ($urandom_range(9) == 0)
        send_item(2'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
      else
        random_graph();
      if ($urandom_range(40) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("%0d transfers in, %0d verdicts checked, %0d with a cycle, %0d with dropped edges",
             sent, sb.results, sb.cycles_seen, sb.drops_seen);
    if (sb.errors == 0 && sb.verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", sb.errors, sb.verdicts.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
